// ===== sv/brf_pkg.sv =====
// Shared types and codes for the byte ring FIFO.
package brf_pkg;

  localparam int MODE_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int OFFSET_W  = 12;
  localparam int COUNT_W   = 13;
  localparam int START_W   = 12;
  localparam int REG_IDX_W = 1;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [OFFSET_W-1:0]  offset_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [START_W-1:0]   start_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam mode_t MODE_PUSH   = 3'd0;
  localparam mode_t MODE_POP    = 3'd1;
  localparam mode_t MODE_PEEK   = 3'd2;
  localparam mode_t MODE_POKE   = 3'd3;
  localparam mode_t MODE_UNREAD = 3'd4;

  localparam reg_idx_t REG_CAPACITY       = 1'd0;
  localparam reg_idx_t REG_START_POSITION = 1'd1;

  localparam byte_t  REFUSED_BYTE   = 8'hFF;
  localparam count_t RESET_CAPACITY = 13'd4096;
  localparam start_t RESET_START    = 12'd0;

endpackage

// ===== sv/brf_if.sv =====
// Handshake channels of the byte ring FIFO: operations, results and configuration.
interface brf_in_if;
  import brf_pkg::*;
  logic    valid;
  logic    ready;
  mode_t   mode;
  byte_t   data_in;
  offset_t offset;
  count_t  count;
  logic    last;
  modport source (output valid, mode, data_in, offset, count, last, input ready);
  modport sink (input valid, mode, data_in, offset, count, last, output ready);
endinterface

interface brf_out_if;
  import brf_pkg::*;
  logic   valid;
  logic   ready;
  byte_t  data_out;
  logic   status;
  count_t moved;
  count_t fill_level;
  logic   last_out;
  modport source (output valid, data_out, status, moved, fill_level, last_out, input ready);
  modport sink (input valid, data_out, status, moved, fill_level, last_out, output ready);
endinterface

interface brf_cfg_if;
  import brf_pkg::*;
  logic     valid;
  logic     ready;
  reg_idx_t index;
  count_t   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/byte_ring_fifo_with_peek.sv =====
// Byte ring FIFO with push, pop, peek, poke and unread over one synchronous memory.
//
//   channel  dir   handshake          payload
//   item     in    valid / ready      mode, data_in, offset, count, last
//   result   out   valid / ready      data_out, status, moved, fill_level, last_out
//   cfg      in    valid / ready      index, data (0 capacity, 1 start_position)
//
// Each transaction goes through acceptance, one memory access with the pointer
// update, and the load of the result register, in that order. The result load
// is a step of its own, since the single memory port registers its read data.
// The result register holds a finished result while the next transaction is
// accepted; a stalled result only delays the result load of the following one.
// Reset is synchronous; the memory needs no clearing pass.
// A configuration write empties the FIFO and takes effect at once. It is taken
// only between transactions and wins over a transaction offered in the same cycle.
module byte_ring_fifo_with_peek #(
  parameter int DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  brf_in_if.sink     item,
  brf_out_if.source  result,
  brf_cfg_if.sink    cfg
);
  import brf_pkg::*;

  // Slot index width and width of fill and free counts.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = ($clog2(DEPTH + 1) > COUNT_W) ? $clog2(DEPTH + 1) : COUNT_W;
  localparam int SW = CW + 1;
  localparam int RESET_CAP = (DEPTH < 4096) ? DEPTH : 4096;

  localparam logic [CW-1:0] DEPTH_C     = CW'(DEPTH);
  localparam logic [CW-1:0] RESET_CAP_C = CW'(RESET_CAP);
  localparam logic [CW-1:0] ONE_C       = CW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  // Control state.
  logic [1:0]    state;
  count_t        capacity;
  start_t        start_position;
  logic [CW-1:0] cap_eff;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] free_space;
  logic [CW-1:0] fill;
  logic          res_valid;

  // The transaction being worked on.
  mode_t   op_mode;
  byte_t   op_data;
  offset_t op_offset;
  count_t  op_count;
  logic    op_last;

  // Outcome of the memory cycle, waiting for the read data.
  logic   pend_status;
  byte_t  pend_byte;
  logic   pend_use_rd;
  count_t pend_moved;
  logic   pend_last;

  // Result register.
  byte_t  res_data;
  logic   res_status;
  count_t res_moved;
  count_t res_fill;
  logic   res_last;

  // The ring store.
  byte_t mem [DEPTH];
  byte_t rd_data;

  logic cfg_we;
  logic item_acc;
  logic res_load;

  count_t        cap_raw_next;
  start_t        start_next;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_eff_next;
  logic [AW-1:0] start_eff_next;

  logic [SW-1:0] off_sum;
  logic [AW-1:0] off_slot;
  logic          off_ok;
  logic [CW-1:0] head_plus;
  logic [CW-1:0] tail_plus;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic [CW-1:0] back_amt;
  logic [AW-1:0] head_back;

  logic          op_ok;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  count_t        moved_now;

  // Configuration is only taken while no transaction is being worked on, and
  // a pending configuration write holds off a new transaction.
  assign cfg.ready  = !rst && (state == S_IDLE);
  assign item.ready = !rst && (state == S_IDLE) && !cfg.valid;
  assign cfg_we     = cfg.valid && cfg.ready;
  assign item_acc   = item.valid && item.ready;
  assign res_load   = (state == S_RESP) && (!res_valid || result.ready);

  assign result.valid      = res_valid;
  assign result.data_out   = res_data;
  assign result.status     = res_status;
  assign result.moved      = res_moved;
  assign result.fill_level = res_fill;
  assign result.last_out   = res_last;

  // A write to either register restarts the ring. Capacity zero acts as one,
  // and anything above the store size acts as the store size.
  always_comb begin
    cap_raw_next = (cfg.index == REG_CAPACITY) ? cfg.data : capacity;
    start_next   = (cfg.index == REG_START_POSITION) ? cfg.data[START_W-1:0] : start_position;
    cap_ext      = CW'(cap_raw_next);
    if (cap_ext == '0) begin
      cap_eff_next = ONE_C;
    end else if (cap_ext > DEPTH_C) begin
      cap_eff_next = DEPTH_C;
    end else begin
      cap_eff_next = cap_ext;
    end
    start_eff_next = (CW'(start_next) < cap_eff_next) ? AW'(start_next) : '0;
  end

  // Slot arithmetic, all modulo the effective capacity.
  always_comb begin
    off_sum   = SW'(head) + SW'(op_offset);
    off_slot  = (off_sum >= SW'(cap_eff)) ? AW'(off_sum - SW'(cap_eff)) : AW'(off_sum);
    off_ok    = CW'(op_offset) < fill;
    head_plus = CW'(head) + ONE_C;
    tail_plus = CW'(tail) + ONE_C;
    head_inc  = (head_plus >= cap_eff) ? '0 : AW'(head_plus);
    tail_inc  = (tail_plus >= cap_eff) ? '0 : AW'(tail_plus);
    // Unread moves back by the smaller of the request and the free space.
    back_amt  = (CW'(op_count) < free_space) ? CW'(op_count) : free_space;
    head_back = (CW'(head) >= back_amt) ? AW'(CW'(head) - back_amt)
                                        : AW'(CW'(head) + (cap_eff - back_amt));
  end

  // Decision for the transaction in the memory cycle.
  always_comb begin
    op_ok     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = head;
    moved_now = '0;
    case (op_mode)
      MODE_PUSH: begin
        op_ok     = free_space != '0;
        mem_addr  = tail;
        moved_now = COUNT_W'(1);
      end
      MODE_POP: begin
        op_ok     = fill != '0;
        mem_addr  = head;
        moved_now = COUNT_W'(1);
      end
      MODE_PEEK: begin
        op_ok    = off_ok;
        mem_addr = off_slot;
      end
      MODE_POKE: begin
        op_ok    = off_ok;
        mem_addr = off_slot;
      end
      MODE_UNREAD: begin
        op_ok     = (fill != '0) && (free_space != '0) && (op_count != '0);
        moved_now = COUNT_W'(back_amt);
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    if (state == S_EXEC && op_ok) begin
      mem_we = (op_mode == MODE_PUSH) || (op_mode == MODE_POKE);
      mem_re = (op_mode == MODE_POP) || (op_mode == MODE_PEEK);
    end
    if (!op_ok) begin
      moved_now = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= op_data;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      op_mode   <= item.mode;
      op_data   <= item.data_in;
      op_offset <= item.offset;
      op_count  <= item.count;
      op_last   <= item.last;
    end
    if (state == S_EXEC) begin
      pend_status <= !op_ok;
      pend_byte   <= op_ok ? '0 : REFUSED_BYTE;
      pend_use_rd <= mem_re;
      pend_moved  <= moved_now;
      pend_last   <= op_last;
    end
    if (res_load) begin
      res_data   <= pend_use_rd ? rd_data : pend_byte;
      res_status <= pend_status;
      res_moved  <= pend_moved;
      res_fill   <= COUNT_W'(fill);
      res_last   <= pend_last;
    end
  end

  // Control state and ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      capacity       <= RESET_CAPACITY;
      start_position <= RESET_START;
      cap_eff        <= RESET_CAP_C;
      head           <= '0;
      tail           <= '0;
      free_space     <= RESET_CAP_C;
      fill           <= '0;
    end else begin
      // A new result replaces the one being taken in the same cycle.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_ok) begin
            case (op_mode)
              MODE_PUSH: begin
                tail       <= tail_inc;
                free_space <= free_space - ONE_C;
                fill       <= fill + ONE_C;
              end
              MODE_POP: begin
                head       <= head_inc;
                free_space <= free_space + ONE_C;
                fill       <= fill - ONE_C;
              end
              MODE_UNREAD: begin
                head       <= head_back;
                free_space <= free_space - back_amt;
                fill       <= fill + back_amt;
              end
              default: begin
                head <= head;
              end
            endcase
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        if (cfg.index == REG_CAPACITY) begin
          capacity <= cfg.data;
        end else begin
          start_position <= cfg.data[START_W-1:0];
        end
        cap_eff    <= cap_eff_next;
        head       <= start_eff_next;
        tail       <= start_eff_next;
        free_space <= cap_eff_next;
        fill       <= '0;
      end
    end
  end

endmodule

// ===== sv/brf_checker.sv =====
// Port-level checks for the byte ring FIFO, bound to the top level.
module brf_checker #(
  parameter int DEPTH = 4096
) (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               res_valid,
  input logic               res_ready,
  input brf_pkg::byte_t     res_data,
  input logic               res_status,
  input brf_pkg::count_t    res_moved,
  input brf_pkg::count_t    res_fill
);
  import brf_pkg::*;

  // A result that is not taken stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before it was taken");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data) && $stable(res_status) &&
                                $stable(res_moved) && $stable(res_fill))
    else $error("stalled result changed");

  // One transaction at a time: no acceptance right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("transaction accepted while one is in progress");

  // A refused transaction returns the refusal byte and moves nothing.
  a_refused: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_data == REFUSED_BYTE && res_moved == '0)
    else $error("refused result with data or movement");

  // The fill level never exceeds the store size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(res_fill) <= DEPTH)
    else $error("fill level beyond store size");

endmodule

bind byte_ring_fifo_with_peek brf_checker #(.DEPTH(DEPTH)) u_brf_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.data_out),
  .res_status (result.status),
  .res_moved  (result.moved),
  .res_fill   (result.fill_level)
);

// ===== sim/tb.sv =====
// Self-checking testbench of the byte ring FIFO with peek, poke and unread.
`timescale 1ns / 100ps

module tb;
  import brf_pkg::*;

  localparam int DEPTH = 4096;

  // Two copies of the ring state are kept. The planning copy runs ahead while
  // stimulus is queued, so that the generator can see which slots hold data.
  // The tracking copy advances only when a transaction is accepted, and it
  // produces the expected outcomes.
  localparam int unsigned PLAN = 0;
  localparam int unsigned LIVE = 1;

  typedef struct packed {
    mode_t   mode;
    byte_t   data;
    offset_t offset;
    count_t  count;
    logic    last;
    logic    drain_first; // hold this operation back until all outcomes are in
  } fifo_op_t;

  typedef struct packed {
    byte_t  data;
    logic   status;
    count_t moved;
    count_t fill;
    logic   last;
  } fifo_outcome_t;

  logic clk = 1'b0;
  logic rst;

  brf_in_if  item_ch ();
  brf_out_if result_ch ();
  brf_cfg_if cfg_ch ();

  byte_ring_fifo_with_peek #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #2 clk = ~clk;

  // Ring state, one copy per index (PLAN, LIVE).
  byte_t       ring_mem  [2][DEPTH];
  bit          ring_set  [2][DEPTH];
  int unsigned head_at   [2];
  int unsigned tail_at   [2];
  int unsigned free_cnt  [2];
  int unsigned cap_reg   [2];
  int unsigned start_reg [2];

  fifo_op_t      op_q[$];
  fifo_outcome_t outcome_q[$];
  fifo_op_t      op_on_bus;
  fifo_outcome_t oldest_due;

  int unsigned queued_n;
  int unsigned accepted_n;
  int unsigned checked_n;
  int unsigned fail_n;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  logic        hold_taken;
  int unsigned hold_left;

  // Zero capacity behaves as one slot, anything above the store size as the
  // whole store.
  function automatic int unsigned eff_cap(int unsigned c);
    if (cap_reg[c] == 0) return 1;
    if (cap_reg[c] > DEPTH) return DEPTH;
    return cap_reg[c];
  endfunction

  // Empties the ring; a start position outside the ring means slot zero.
  function automatic void restart_ring(int unsigned c);
    int unsigned cap;
    cap = eff_cap(c);
    head_at[c]  = (start_reg[c] < cap) ? start_reg[c] : 0;
    tail_at[c]  = head_at[c];
    free_cnt[c] = cap;
  endfunction

  function automatic void write_reg(int unsigned c, reg_idx_t idx, count_t val);
    if (idx == REG_CAPACITY) begin
      cap_reg[c] = 32'(val);
    end else begin
      start_reg[c] = 32'(val[START_W-1:0]);
    end
    restart_ring(c);
  endfunction

  function automatic int unsigned ring_next(int unsigned a, int unsigned b, int unsigned cap);
    int unsigned s;
    s = a + b;
    return (s >= cap) ? s - cap : s;
  endfunction

  // Applies one operation to a copy of the ring and returns its outcome.
  function automatic fifo_outcome_t apply_op(int unsigned c, fifo_op_t op);
    fifo_outcome_t r;
    int unsigned   cap;
    int unsigned   fill;
    int unsigned   slot;
    int unsigned   back;
    cap      = eff_cap(c);
    fill     = cap - free_cnt[c];
    r.data   = REFUSED_BYTE;
    r.status = 1'b1;
    r.moved  = '0;
    r.last   = op.last;
    case (op.mode)
      MODE_PUSH: begin
        if (free_cnt[c] != 0) begin
          ring_mem[c][tail_at[c]] = op.data;
          ring_set[c][tail_at[c]] = 1'b1;
          tail_at[c] = ring_next(tail_at[c], 1, cap);
          free_cnt[c]--;
          r.data   = '0;
          r.status = 1'b0;
          r.moved  = count_t'(1);
        end
      end
      MODE_POP: begin
        if (fill != 0) begin
          r.data     = ring_mem[c][head_at[c]];
          head_at[c] = ring_next(head_at[c], 1, cap);
          free_cnt[c]++;
          r.status = 1'b0;
          r.moved  = count_t'(1);
        end
      end
      MODE_PEEK: begin
        if (op.offset < fill) begin
          slot     = ring_next(head_at[c], op.offset, cap);
          r.data   = ring_mem[c][slot];
          r.status = 1'b0;
        end
      end
      MODE_POKE: begin
        if (op.offset < fill) begin
          slot = ring_next(head_at[c], op.offset, cap);
          ring_mem[c][slot] = op.data;
          ring_set[c][slot] = 1'b1;
          r.data   = '0;
          r.status = 1'b0;
        end
      end
      MODE_UNREAD: begin
        // Unread only works on a ring that is neither empty nor full, and it
        // moves the head back by at most the free space.
        if (fill != 0 && free_cnt[c] != 0 && op.count != 0) begin
          back = (op.count < free_cnt[c]) ? op.count : free_cnt[c];
          head_at[c] = ring_next(head_at[c], cap - back, cap);
          free_cnt[c] -= back;
          r.data   = '0;
          r.status = 1'b0;
          r.moved  = count_t'(back);
        end
      end
      default: begin
      end
    endcase
    r.fill = count_t'(cap - free_cnt[c]);
    return r;
  endfunction

  // Builds a random operation against the planning copy. Pops and peeks that
  // would land on a slot never written are turned into pushes, since the
  // store holds no defined value there.
  function automatic fifo_op_t random_op(int unsigned push_pct);
    fifo_op_t    op;
    int unsigned cap;
    int unsigned fill;
    int unsigned roll;
    cap            = eff_cap(PLAN);
    fill           = cap - free_cnt[PLAN];
    op             = '0;
    op.data        = byte_t'($urandom_range(0, 255));
    op.last        = 1'($urandom_range(0, 1));
    op.offset      = offset_t'($urandom_range(0, 4095));
    op.count       = count_t'($urandom_range(0, 8191));
    if ($urandom_range(0, 99) < push_pct) begin
      op.mode = MODE_PUSH;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) op.mode = MODE_POP;
      else if (roll < 65) op.mode = MODE_PEEK;
      else if (roll < 80) op.mode = MODE_POKE;
      else if (roll < 96) op.mode = MODE_UNREAD;
      else op.mode = mode_t'($urandom_range(5, 7));
    end
    // Most peeks and pokes stay within or just past the fill level.
    if ($urandom_range(0, 99) < 80) begin
      op.offset = offset_t'($urandom_range(0, (fill > 4095) ? 4095 : fill));
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      op.count = count_t'($urandom_range(1, free_cnt[PLAN] + 1));
    end else if (roll < 80) begin
      op.count = '0;
    end
    if (op.mode == MODE_POP && fill != 0 && !ring_set[PLAN][head_at[PLAN]]) begin
      op.mode = MODE_PUSH;
    end
    if (op.mode == MODE_PEEK && op.offset < fill &&
        !ring_set[PLAN][ring_next(head_at[PLAN], op.offset, cap)]) begin
      op.mode = MODE_PUSH;
    end
    return op;
  endfunction

  function automatic void queue_op(fifo_op_t op);
    void'(apply_op(PLAN, op));
    op_q.push_back(op);
    queued_n++;
  endfunction

  task automatic directed(mode_t m, byte_t d, offset_t o, count_t n, logic l);
    fifo_op_t op;
    op = '{mode: m, data: d, offset: o, count: n, last: l, drain_first: 1'b0};
    queue_op(op);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_n++;
    end
  endfunction

  // Returns once every queued operation has been accepted and its outcome
  // has been checked, right after a rising edge.
  task automatic wait_idle();
    do @(posedge clk); while (accepted_n != queued_n || checked_n != accepted_n);
  endtask

  // Writes capacity, then start position. Valid stays high across both writes.
  task automatic set_config(count_t cap_val, count_t start_val);
    count_t vals [2];
    vals[0] = cap_val;
    vals[1] = start_val;
    for (int i = 0; i < 2; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_t'(i);
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      write_reg(LIVE, reg_idx_t'(i), vals[i]);
      write_reg(PLAN, reg_idx_t'(i), vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One configuration phase of random traffic. With pressure set, the
  // receiver holds off for a long stretch while the sender keeps offering,
  // and halfway through the sender waits for every outcome to come back.
  task automatic run_phase(count_t cap_val, count_t start_val, int n, int unsigned push_pct,
                           int unsigned send_pct, int unsigned recv_pct, bit pressure);
    fifo_op_t op;
    wait_idle();
    set_config(cap_val, start_val);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    if (pressure) hold_req <= 1'b1;
    for (int i = 0; i < n; i++) begin
      op = random_op(push_pct);
      if (pressure && i == n / 2) op.drain_first = 1'b1;
      queue_op(op);
    end
  endtask

  // Driver: offers the oldest pending operation whenever the channel is free,
  // unless it rolls an idle cycle. The expected outcome of a transaction is
  // worked out at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        outcome_q.push_back(apply_op(LIVE, op_on_bus));
        accepted_n <= accepted_n + 1;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            (!op_q[0].drain_first || (!item_ch.valid && accepted_n == checked_n))) begin
          op_on_bus = op_q.pop_front();
          item_ch.valid   <= 1'b1;
          item_ch.mode    <= op_on_bus.mode;
          item_ch.data_in <= op_on_bus.data;
          item_ch.offset  <= op_on_bus.offset;
          item_ch.count   <= op_on_bus.count;
          item_ch.last    <= op_on_bus.last;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so it runs independently of the
  // random stalls in the monitor.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= 400;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with no expected outcome pending");
          fail_n++;
        end else begin
          oldest_due = outcome_q.pop_front();
          check_field("data_out", oldest_due.data, result_ch.data_out);
          check_field("status", oldest_due.status, result_ch.status);
          check_field("moved", oldest_due.moved, result_ch.moved);
          check_field("fill_level", oldest_due.fill, result_ch.fill_level);
          check_field("last_out", oldest_due.last, result_ch.last_out);
          checked_n <= checked_n + 1;
        end
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.mode    = MODE_PUSH;
    item_ch.data_in = '0;
    item_ch.offset  = '0;
    item_ch.count   = '0;
    item_ch.last    = 1'b0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_CAPACITY;
    cfg_ch.data     = '0;
    queued_n        = 0;
    accepted_n      = 0;
    checked_n       = 0;
    fail_n          = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    for (int c = 0; c < 2; c++) begin
      cap_reg[c]   = RESET_CAPACITY;
      start_reg[c] = RESET_START;
      restart_ring(c);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a three-slot ring starting at slot two, so the tail
    // and head wrap right away.
    set_config(13'd3, 13'd2);
    directed(MODE_PUSH,   8'h00, 12'd0,    13'd0,    1'b0);
    directed(MODE_PUSH,   8'hFF, 12'd0,    13'd0,    1'b1);
    directed(MODE_PUSH,   8'h5A, 12'd0,    13'd0,    1'b0);
    directed(MODE_PUSH,   8'h11, 12'd0,    13'd0,    1'b0); // full: refused
    directed(MODE_UNREAD, 8'h00, 12'd0,    13'd1,    1'b0); // full: refused
    directed(MODE_PEEK,   8'h00, 12'd2,    13'd0,    1'b1);
    directed(MODE_PEEK,   8'h00, 12'd3,    13'd0,    1'b0); // at fill level
    directed(MODE_PEEK,   8'h00, 12'd4095, 13'd0,    1'b0);
    directed(MODE_POKE,   8'h00, 12'd1,    13'd0,    1'b0);
    directed(MODE_POKE,   8'hFF, 12'd3,    13'd0,    1'b1); // at fill level
    directed(MODE_POP,    8'h00, 12'd0,    13'd0,    1'b0);
    directed(MODE_UNREAD, 8'h00, 12'd0,    13'd0,    1'b0); // count zero
    directed(MODE_UNREAD, 8'h00, 12'd0,    13'd8191, 1'b1); // clipped to free space
    directed(MODE_POP,    8'h00, 12'd0,    13'd0,    1'b0);
    directed(MODE_POP,    8'h00, 12'd0,    13'd0,    1'b0);
    directed(MODE_POP,    8'h00, 12'd0,    13'd0,    1'b1);
    directed(MODE_POP,    8'h00, 12'd0,    13'd0,    1'b0); // empty: refused
    directed(MODE_UNREAD, 8'h00, 12'd0,    13'd5,    1'b0); // empty: refused
    directed(MODE_PEEK,   8'h00, 12'd0,    13'd0,    1'b0); // empty: refused
    directed(mode_t'(5),  8'h00, 12'd0,    13'd0,    1'b0);
    directed(mode_t'(6),  8'hFF, 12'd4095, 13'd8191, 1'b1);
    directed(mode_t'(7),  8'h00, 12'd0,    13'd0,    1'b0);
    directed(MODE_PUSH,   8'hFF, 12'd4095, 13'd8191, 1'b1);
    directed(MODE_POKE,   8'h00, 12'd0,    13'd0,    1'b0);
    directed(MODE_POP,    8'h00, 12'd0,    13'd0,    1'b1);

    // Random phases over a range of ring sizes and starting slots, cycling
    // through the idle patterns. Capacity zero and values past the store,
    // and start positions at or past the capacity, are all covered.
    run_phase(13'd1,    13'd0,    80,  45, 58, 0,  1'b0);
    run_phase(13'd0,    13'd4095, 60,  45, 0,  58, 1'b0);
    run_phase(13'd4096, 13'd4095, 150, 60, 12, 12, 1'b0);
    run_phase(13'd8191, 13'd8191, 80,  50, 0,  0,  1'b0);
    run_phase(13'd7,    13'd5,    200, 40, 0,  0,  1'b1);
    run_phase(13'd16,   13'd0,    200, 40, 58, 0,  1'b0);
    run_phase(count_t'($urandom_range(2, 64)), count_t'($urandom_range(0, 8191)),
              230, 40, 0, 58, 1'b0);
    run_phase(count_t'($urandom_range(2, 9)), count_t'($urandom_range(0, 8)),
              100, 40, 12, 12, 1'b0);

    wait_idle();
    // Leave room for any stray result.
    repeat (10) @(posedge clk);
    if (fail_n == 0 && outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== byte_ring_fifo_with_peek.f =====
sv/brf_pkg.sv
sv/brf_if.sv
sv/byte_ring_fifo_with_peek.sv
sv/brf_checker.sv
sim/tb.sv
